/* rtl/core/glu_pkg.sv */
package glu_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } glu_state_e;

endpackage

/* rtl/core/gcd_lcm_unit.sv */
// Sequence: binary GCD steps until both operands match, a scale step, VALUE_BITS divide steps,
// VALUE_BITS multiply steps and a load step that waits while the output is stalled; a zero
// operand goes straight to the load step. Only one beat is in flight: a new input beat is
// taken only once the sequencer is back in idle.
// A single shared add/subtract unit serves the GCD, divide and multiply steps.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops the result.
module gcd_lcm_unit #(
  parameter int unsigned VALUE_BITS = 31,
  localparam int unsigned InW  = ((2 * VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((3 * VALUE_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,  // first_value, second_value
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata   // common_divisor, common_multiple
);
  import glu_pkg::*;

  localparam int unsigned W    = VALUE_BITS;
  localparam int unsigned CntW = $clog2(VALUE_BITS);
  localparam int unsigned AddW = VALUE_BITS + 2;

  glu_state_e state_q, state_d;

  logic [W-1:0]    a_q, a_d, b_q, b_d, g_q, g_d, y_q, y_d;
  logic [W-1:0]    d_q, d_d, rem_q, rem_d;
  logic [2*W-1:0]  prod_q, prod_d;
  logic [CntW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_div_q, out_div_d;
  logic [2*W-1:0]  out_mul_q, out_mul_d;

  logic [AddW-1:0] add_a, add_b, add_res;
  logic            add_sub;
  logic            in_beat, out_free, a_lt_b, borrow;
  logic [W-1:0]    in_x, in_y;

  assign in_x     = s_axis_tdata[W-1:0];
  assign in_y     = s_axis_tdata[2*W-1:W];
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign a_lt_b   = a_q < b_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_mul_q, out_div_q});

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b1;
    case (state_q)
      ST_GCD: begin
        add_a = AddW'(a_lt_b ? b_q : a_q);
        add_b = AddW'(a_lt_b ? a_q : b_q);
      end
      ST_DIV: begin
        add_a = AddW'({rem_q, d_q[W-1]});
        add_b = AddW'(g_q);
      end
      ST_MUL: begin
        add_a   = AddW'(prod_q[2*W-1:W]);
        add_b   = AddW'(y_q);
        add_sub = 1'b0;
      end
      default: ;
    endcase
    add_res = add_a + (add_sub ? ~add_b : add_b) + AddW'(add_sub);
  end

  assign borrow = add_res[AddW-1];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = (in_x == '0 || in_y == '0) ? ST_DONE : ST_GCD;
        end
      end
      ST_GCD: begin
        if (a_q == b_q) state_d = ST_SCALE;
      end
      ST_SCALE: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    g_d         = g_q;
    y_d         = y_q;
    d_d         = d_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    out_div_d   = out_div_q;
    out_mul_d   = out_mul_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        a_d    = in_x;
        b_d    = in_y;
        y_d    = in_y;
        d_d    = in_x;
        k_d    = '0;
        g_d    = in_x | in_y;
        prod_d = '0;
      end
      ST_GCD: begin
        if (a_q != b_q) begin
          if (!a_q[0] && !b_q[0]) begin
            a_d = a_q >> 1;
            b_d = b_q >> 1;
            k_d = k_q + 1'b1;
          end else if (!a_q[0]) begin
            a_d = a_q >> 1;
          end else if (!b_q[0]) begin
            b_d = b_q >> 1;
          end else if (a_lt_b) begin
            b_d = add_res[W:1];
          end else begin
            a_d = add_res[W:1];
          end
        end
      end
      ST_SCALE: begin
        g_d   = a_q << k_q;
        rem_d = '0;
        cnt_d = CntW'(VALUE_BITS - 1);
      end
      ST_DIV: begin
        rem_d = borrow ? {rem_q[W-2:0], d_q[W-1]} : add_res[W-1:0];
        d_d   = {d_q[W-2:0], !borrow};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          prod_d = {{W{1'b0}}, d_q[W-2:0], !borrow};
          cnt_d  = CntW'(VALUE_BITS - 1);
        end
      end
      ST_MUL: begin
        prod_d = prod_q[0] ? {add_res[W:0], prod_q[W-1:1]} : (prod_q >> 1);
        cnt_d  = cnt_q - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_div_d   = g_q;
          out_mul_d   = prod_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    g_q       <= g_d;
    y_q       <= y_d;
    d_q       <= d_d;
    rem_q     <= rem_d;
    prod_q    <= prod_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    out_div_q <= out_div_d;
    out_mul_q <= out_mul_d;
  end

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input taken while a beat is in flight");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GCD |-> (a_q != '0 && b_q != '0))
    else $error("gcd operand reached zero");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < g_q)
    else $error("divide remainder not below divisor");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> m_axis_tvalid)
    else $error("finished result not presented");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned VALUE_BITS  = 31;
  localparam int unsigned IN_W        = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((3 * VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned LATENCY     = 4 * VALUE_BITS + 3;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 800;

  typedef logic [VALUE_BITS-1:0] operand_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]   divisor;
    logic [2*VALUE_BITS-1:0] multiple;
  } gcd_lcm_t;

  typedef struct packed {
    operand_t first;
    operand_t second;
    gcd_lcm_t want;
  } pending_pair_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  pending_pair_t pending_results[$];
  int unsigned   pairs_sent    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   mismatches    = 0;
  int unsigned   stuck_cycles  = 0;
  int unsigned   rx_hold_left  = 0;
  bit            tx_gaps       = 1'b0;
  bit            rx_stalls     = 1'b0;

  gcd_lcm_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic gcd_lcm_t predict_gcd_lcm(operand_t a, operand_t b);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] prod;
    gcd_lcm_t    res;
    x = 64'(a);
    y = 64'(b);
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    prod = 64'd0;
    if (a != '0 && b != '0) begin
      prod = (64'(a) / x) * 64'(b);
    end
    res.divisor  = x[VALUE_BITS-1:0];
    res.multiple = prod[2*VALUE_BITS-1:0];
    return res;
  endfunction

  function automatic operand_t rand_value(int unsigned bits);
    logic [31:0] v;
    v = $urandom;
    if (bits < 32) begin
      v = v & ((32'd1 << bits) - 32'd1);
    end
    if (v[VALUE_BITS-1:0] == '0) begin
      v = 32'd1;
    end
    return v[VALUE_BITS-1:0];
  endfunction

  task automatic make_pair(output operand_t a, output operand_t b);
    int unsigned fb;
    operand_t    g;
    operand_t    t;
    fb = $urandom_range(1, VALUE_BITS - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        a = rand_value(VALUE_BITS);
        b = rand_value(VALUE_BITS);
      end
      3, 4: begin
        g = rand_value(fb);
        a = g * rand_value(VALUE_BITS - fb);
        b = g * rand_value(VALUE_BITS - fb);
      end
      5: begin
        a = operand_t'($urandom_range(1, 1000));
        b = operand_t'($urandom_range(1, 1000));
      end
      6: begin
        a = rand_value($urandom_range(1, VALUE_BITS));
        b = a;
      end
      7: begin
        a = operand_t'(1) << $urandom_range(0, VALUE_BITS - 1);
        b = rand_value($urandom_range(1, VALUE_BITS));
      end
      8: begin
        b = rand_value(fb);
        a = b * rand_value(VALUE_BITS - fb);
      end
      default: begin
        a = rand_value($urandom_range(1, VALUE_BITS));
        b = rand_value($urandom_range(1, VALUE_BITS));
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      t = a;
      a = b;
      b = t;
    end
  endtask

  task automatic send_pair(input operand_t a, input operand_t b);
    pending_pair_t entry;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tdata  = IN_W'({b, a});
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    entry.first  = a;
    entry.second = b;
    entry.want   = predict_gcd_lcm(a, b);
    pending_results.push_back(entry);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    operand_t a;
    operand_t b;
    repeat (count) begin
      make_pair(a, b);
      send_pair(a, b);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    operand_t max_v;
    max_v     = '1;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_pair(operand_t'(1), operand_t'(1));
    send_pair(max_v, max_v);
    send_pair(operand_t'(1), max_v);
    send_pair(max_v, operand_t'(1));
    send_pair(operand_t'(12345), operand_t'(12345));
    send_pair(operand_t'(1 << 30), operand_t'(1 << 30));
    send_pair(max_v, operand_t'(2147483629));
    send_pair(operand_t'(1 << 30), operand_t'(1 << 20));
    send_pair(operand_t'(32'h5555_5555), operand_t'(32'h2AAA_AAAA));
    send_pair(operand_t'(6), operand_t'(4));
    send_pair(operand_t'(12), operand_t'(18));
    send_pair(max_v, operand_t'(2));
    send_pair(operand_t'(2), max_v);
    send_pair(operand_t'(196608), operand_t'(327680));
    send_pair(operand_t'(1836311903), operand_t'(1134903170));
    send_pair(operand_t'(1134903170), operand_t'(1836311903));
    send_pair(operand_t'(1 << 30), max_v);
    send_pair(operand_t'(0), operand_t'(5));
    send_pair(max_v, operand_t'(0));
    send_pair(operand_t'(0), operand_t'(0));
    wait_drain();
  endtask

  task automatic test_random_traffic(int unsigned count);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_random(count);
  endtask

  task automatic test_output_backpressure();
    tx_gaps      = 1'b0;
    rx_stalls    = 1'b0;
    rx_hold_left = HOLD_CYCLES;
    send_random(30);
  endtask

  task automatic test_drain_then_resume();
    wait_drain();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_random(60);
  endtask

  task automatic test_full_rate(int unsigned count);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_random(count);
  endtask

  // hold the output side low in random bursts, or for a long counted stretch on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left != 0) begin
        m_axis_tready = 1'b0;
        repeat (rx_hold_left) @(negedge clk_i);
        rx_hold_left = 0;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    gcd_lcm_t      got;
    pending_pair_t exp_item;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.divisor  = m_axis_tdata[VALUE_BITS-1:0];
      got.multiple = m_axis_tdata[3*VALUE_BITS-1:VALUE_BITS];
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: divisor %0d multiple %0d", got.divisor, got.multiple);
        end
      end else begin
        exp_item = pending_results.pop_front();
        if (got.divisor !== exp_item.want.divisor) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("divisor mismatch for (%0d, %0d): expected %0d, got %0d",
                     exp_item.first, exp_item.second, exp_item.want.divisor, got.divisor);
          end
        end
        if (got.multiple !== exp_item.want.multiple) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("multiple mismatch for (%0d, %0d): expected %0d, got %0d",
                     exp_item.first, exp_item.second, exp_item.want.multiple, got.multiple);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (s_axis_tvalid || pending_results.size() != 0) begin
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", stuck_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_traffic(1400);
    test_output_backpressure();
    test_drain_then_resume();
    test_full_rate(341);

    wait_drain();
    repeat (LATENCY) @(negedge clk_i);

    $display("sent %0d operand pairs, checked %0d results", pairs_sent, results_seen);
    $display("covered edge values, zero operands, shared factors, divisors, powers of two,");
    $display("random stalls, a long output hold-off and a full drain");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
